[rtl/fprd_pkg.sv]
// Shared types and constants of the fixed-predictor Rice decoder.
// Holds the status codes, field widths and the result record.
// No dependencies; every other file refers to it by scoped names.
package fprd_pkg;

   // Largest zigzag code that a residual may take.
   localparam int MAX_ZIGZAG = 1048575;
   localparam int ZIG_W = $clog2(MAX_ZIGZAG + 1);
   // Quotient counter: one above the largest legal quotient must fit.
   localparam int Q_W = ZIG_W + 1;
   // Predictor sum of four 16-bit samples needs 20 bits; the residual ZIG_W.
   localparam int SUM_W = ((ZIG_W > 20) ? ZIG_W : 20) + 1;

   localparam int SAMPLE_W = 16;
   localparam int CFG_W = 16;
   localparam int DATA_W = 32;
   localparam int PADDR_W = 3;
   localparam int HIST_DEPTH = 4;

   localparam logic [CFG_W-1:0] EXPECTED_RESET = 16'd2;
   localparam logic [CFG_W-1:0] MIN_EXPECTED = 16'd2;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [2:0] status_type;

   localparam status_type ST_OK        = 3'd0;
   localparam status_type ST_BAD_ARG   = 3'd1;
   localparam status_type ST_TRUNC     = 3'd2;
   localparam status_type ST_VERSION   = 3'd3;
   localparam status_type ST_PREDICTOR = 3'd4;
   localparam status_type ST_PARAM     = 3'd5;
   localparam status_type ST_RESIDUAL  = 3'd6;
   localparam status_type ST_SAMPLE    = 3'd7;

   // Register index of expected_samples on the configuration port.
   localparam logic REG_EXPECTED = 1'b0;

   // One result as produced by the frame logic.
   typedef struct packed {
      logic       valid;
      sample_type sample;
      status_type status;
      logic       last;
   } result_type;

endpackage

[rtl/fprd_csr.sv]
// Configuration register block of the Rice decoder: the APB-style port
// and the expected_samples register. Depends on fprd_pkg.
module fprd_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [fprd_pkg::PADDR_W-1:0]   paddr,
   input  logic [fprd_pkg::DATA_W-1:0]    pwdata,
   output logic [fprd_pkg::DATA_W-1:0]    prdata,
   output logic                           pready,
   output logic [fprd_pkg::CFG_W-1:0]     expected_samples
);

   logic [fprd_pkg::CFG_W-1:0] expected_ff;
   logic [fprd_pkg::CFG_W-1:0] expected_in;
   logic                       reg_hit;

   // Word index is the address bit above the byte offset.
   assign reg_hit = (paddr[fprd_pkg::PADDR_W-1] == fprd_pkg::REG_EXPECTED);

   always_comb begin
      expected_in = expected_ff;
      if (psel && penable && pwrite && pready && reg_hit) begin
         expected_in = pwdata[fprd_pkg::CFG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= fprd_pkg::EXPECTED_RESET;
      end else begin
         expected_ff <= expected_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = reg_hit ? fprd_pkg::DATA_W'(expected_ff) : '0;
   assign expected_samples = expected_ff;

endmodule

[rtl/fprd_predict.sv]
// Fixed polynomial predictor plus zigzag residual for the Rice decoder.
// Purely combinational; depends on fprd_pkg.
module fprd_predict (
   input  fprd_pkg::sample_type           hist [fprd_pkg::HIST_DEPTH],
   input  logic [2:0]                     order,
   input  logic [fprd_pkg::ZIG_W-1:0]     zig,
   output fprd_pkg::sample_type           sample,
   output logic                           overflow
);

   localparam logic signed [fprd_pkg::SUM_W-1:0] LO = fprd_pkg::SUM_W'(-32768);
   localparam logic signed [fprd_pkg::SUM_W-1:0] HI = fprd_pkg::SUM_W'(32767);

   logic signed [fprd_pkg::SUM_W-1:0] a, b, c, d;
   logic signed [fprd_pkg::SUM_W-1:0] pred;
   logic        [fprd_pkg::ZIG_W-1:0] half;
   logic signed [fprd_pkg::ZIG_W-1:0] res;
   logic signed [fprd_pkg::SUM_W-1:0] sum;

   assign a = fprd_pkg::SUM_W'(hist[0]);
   assign b = fprd_pkg::SUM_W'(hist[1]);
   assign c = fprd_pkg::SUM_W'(hist[2]);
   assign d = fprd_pkg::SUM_W'(hist[3]);

   // The coefficients are built from shifts and adds at the sum width.
   always_comb begin
      case (order)
         3'd1:    pred = a;
         3'd2:    pred = (a <<< 1) - b;
         3'd3:    pred = (a <<< 1) + a - (b <<< 1) - b + c;
         default: pred = (a <<< 2) - (b <<< 2) - (b <<< 1) + (c <<< 2) - d;
      endcase
   end

   // Odd codes are negative residuals: -(zig >> 1) - 1 is the complement.
   assign half = {1'b0, zig[fprd_pkg::ZIG_W-1:1]};
   assign res  = zig[0] ? ~half : half;

   assign sum      = pred + fprd_pkg::SUM_W'(res);
   assign overflow = (sum < LO) || (sum > HI);
   assign sample   = sum[fprd_pkg::SAMPLE_W-1:0];

endmodule

[rtl/fprd_frame.sv]
// Frame parser of the Rice decoder: header, seeds and Rice codes, one bit
// per step, with the sample history. Depends on fprd_pkg and fprd_predict.
module fprd_frame (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fire,
   input  logic                         bit_value,
   input  logic                         first_bit,
   input  logic                         last_bit,
   input  logic [fprd_pkg::CFG_W-1:0]   expected_samples,
   output fprd_pkg::result_type         result
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HEADER,
      PH_SEED,
      PH_QUOT,
      PH_REM,
      PH_DONE
   } phase_type;

   phase_type                    phase_ff, phase_in;
   logic [15:0]                  shift_ff, shift_in;
   logic [3:0]                   idx_ff, idx_in;
   logic [1:0]                   version_ff, version_in;
   logic [2:0]                   order_ff, order_in;
   logic [3:0]                   k_ff, k_in;
   logic [fprd_pkg::Q_W-1:0]     quot_ff, quot_in;
   logic [14:0]                  rem_ff, rem_in;
   fprd_pkg::sample_type         hist_ff [fprd_pkg::HIST_DEPTH];
   fprd_pkg::sample_type         hist_in [fprd_pkg::HIST_DEPTH];
   logic [2:0]                   fill_ff, fill_in;
   logic [15:0]                  done_ff, done_in;

   logic [15:0]                  shift_new;
   logic [7:0]                   hdr_version, hdr_control, hdr_order, hdr_k;
   logic [14:0]                  rem_code;
   logic [31:0]                  zig;
   logic [31:0]                  quot_limit;
   fprd_pkg::sample_type         pred_sample;
   logic                         pred_over;
   fprd_pkg::status_type         err;
   fprd_pkg::sample_type         val;
   logic                         active, bad_arg, have, final_s, code_done, seed_done;

   function automatic logic [2:0] seeds_for(input logic [1:0] version,
                                            input logic [2:0] order);
      return (version == 2'd3) ? order : 3'd2;
   endfunction

   // The Rice code value, formed from the stored quotient and remainder.
   always_comb begin
      rem_code = '0;
      if (phase_ff == PH_REM) begin
         rem_code = rem_ff | (15'(bit_value) << idx_ff);
      end
      zig        = (32'(quot_ff) << k_ff) | 32'(rem_code);
      quot_limit = 32'(fprd_pkg::MAX_ZIGZAG) >> k_ff;
   end

   fprd_predict u_predict (
      .hist     (hist_ff),
      .order    (order_ff),
      .zig      (zig[fprd_pkg::ZIG_W-1:0]),
      .sample   (pred_sample),
      .overflow (pred_over)
   );

   always_comb begin
      phase_in   = phase_ff;
      shift_in   = shift_ff;
      idx_in     = idx_ff;
      version_in = version_ff;
      order_in   = order_ff;
      k_in       = k_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      hist_in    = hist_ff;
      fill_in    = fill_ff;
      done_in    = done_ff;
      err        = fprd_pkg::ST_OK;
      val        = '0;
      bad_arg    = 1'b0;
      have       = 1'b0;
      final_s    = 1'b0;
      code_done  = 1'b0;
      seed_done  = 1'b0;
      hdr_version = shift_in[7:0];
      hdr_control = shift_in[15:8];
      hdr_order   = '0;
      hdr_k       = '0;
      result      = '0;

      // A first bit restarts the frame from a clean state.
      if (first_bit) begin
         phase_in   = PH_HEADER;
         shift_in   = '0;
         idx_in     = '0;
         version_in = '0;
         order_in   = '0;
         k_in       = '0;
         quot_in    = '0;
         rem_in     = '0;
         for (int i = 0; i < fprd_pkg::HIST_DEPTH; i++) begin
            hist_in[i] = '0;
         end
         fill_in = '0;
         done_in = '0;
         if (expected_samples < fprd_pkg::MIN_EXPECTED) begin
            phase_in = PH_DONE;
            bad_arg  = 1'b1;
         end
      end

      active    = !bad_arg && (phase_in inside {PH_HEADER, PH_SEED, PH_QUOT, PH_REM});
      shift_new = shift_in | (16'(bit_value) << idx_in);
      hdr_version = shift_new[7:0];
      hdr_control = shift_new[15:8];

      case (phase_in)
         PH_HEADER, PH_SEED: begin
            if (idx_in != 4'd15) begin
               idx_in   = idx_in + 4'd1;
               shift_in = shift_new;
            end else begin
               idx_in   = '0;
               shift_in = '0;
               if (phase_in == PH_HEADER) begin
                  phase_in = PH_SEED;
                  if (hdr_version == 8'd1) begin
                     hdr_order = 8'd2;
                     hdr_k     = hdr_control;
                  end else if (hdr_version inside {8'd2, 8'd3}) begin
                     hdr_order = {4'd0, hdr_control[7:4]};
                     hdr_k     = {4'd0, hdr_control[3:0]};
                  end else begin
                     err = fprd_pkg::ST_VERSION;
                  end
                  if (err == fprd_pkg::ST_OK) begin
                     if (hdr_order < 8'd1 || hdr_order > 8'd4 ||
                         (hdr_version != 8'd3 && hdr_order > 8'd2)) begin
                        err = fprd_pkg::ST_PREDICTOR;
                     end else if (hdr_k > 8'd15) begin
                        err = fprd_pkg::ST_PARAM;
                     end else begin
                        version_in = hdr_version[1:0];
                        order_in   = hdr_order[2:0];
                        k_in       = hdr_k[3:0];
                        if (expected_samples < 16'(seeds_for(version_in, order_in))) begin
                           err = fprd_pkg::ST_TRUNC;
                        end
                     end
                  end
               end else begin
                  val       = shift_new;
                  have      = 1'b1;
                  seed_done = 1'b1;
               end
            end
         end
         PH_QUOT: begin
            if (bit_value) begin
               rem_in = '0;
               idx_in = '0;
               if (k_in == 4'd0) begin
                  code_done = 1'b1;
               end else begin
                  phase_in = PH_REM;
               end
            end else begin
               quot_in = quot_in + 1'b1;
               if (32'(quot_in) > quot_limit) begin
                  err = fprd_pkg::ST_RESIDUAL;
               end
            end
         end
         PH_REM: begin
            rem_in = rem_code;
            idx_in = idx_in + 4'd1;
            if (idx_in >= k_in) begin
               code_done = 1'b1;
            end
         end
         default: ;
      endcase

      if (code_done) begin
         if (zig > 32'(fprd_pkg::MAX_ZIGZAG)) begin
            err = fprd_pkg::ST_RESIDUAL;
         end else if (pred_over) begin
            err = fprd_pkg::ST_SAMPLE;
         end else begin
            val      = pred_sample;
            have     = 1'b1;
            phase_in = PH_QUOT;
            quot_in  = '0;
            rem_in   = '0;
            idx_in   = '0;
         end
      end

      // Push a completed seed or sample into the history.
      if (have) begin
         hist_in[3] = hist_in[2];
         hist_in[2] = hist_in[1];
         hist_in[1] = hist_in[0];
         hist_in[0] = val;
         if (fill_in < 3'd4) begin
            fill_in = fill_in + 3'd1;
         end
         done_in = done_in + 16'd1;
         final_s = (done_in >= expected_samples);
      end

      if (seed_done && !final_s && fill_in >= seeds_for(version_in, order_in)) begin
         phase_in = PH_QUOT;
      end

      if (bad_arg) begin
         result = '{valid: 1'b1, sample: '0, status: fprd_pkg::ST_BAD_ARG, last: 1'b1};
      end else if (active) begin
         if (err != fprd_pkg::ST_OK) begin
            phase_in = PH_DONE;
            result   = '{valid: 1'b1, sample: '0, status: err, last: 1'b1};
         end else if (have && final_s) begin
            phase_in = PH_DONE;
            result   = '{valid: 1'b1, sample: val, status: fprd_pkg::ST_OK, last: 1'b1};
         end else if (last_bit) begin
            phase_in = PH_DONE;
            result   = '{valid: 1'b1, sample: '0, status: fprd_pkg::ST_TRUNC, last: 1'b1};
         end else if (have) begin
            result   = '{valid: 1'b1, sample: val, status: fprd_pkg::ST_OK, last: 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         shift_ff   <= '0;
         idx_ff     <= '0;
         version_ff <= '0;
         order_ff   <= '0;
         k_ff       <= '0;
         quot_ff    <= '0;
         rem_ff     <= '0;
         for (int i = 0; i < fprd_pkg::HIST_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
         fill_ff    <= '0;
         done_ff    <= '0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         shift_ff   <= shift_in;
         idx_ff     <= idx_in;
         version_ff <= version_in;
         order_ff   <= order_in;
         k_ff       <= k_in;
         quot_ff    <= quot_in;
         rem_ff     <= rem_in;
         hist_ff    <= hist_in;
         fill_ff    <= fill_in;
         done_ff    <= done_in;
      end
   end

endmodule

[rtl/fixed_predictor_rice_decoder.sv]
// A request accepted at a rising edge is held in the request register; the frame
// logic then decodes it into the result register, from which its result can be
// taken. Throughput: one request per cycle.
// Stalls come only from the result side: a result held with rsp_ready low
// halts the frame logic, and req_ready falls once the request register fills.
// Reset is synchronous and active high; it empties both pipeline registers,
// returns the frame to idle and sets expected_samples to 2.
module fixed_predictor_rice_decoder (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel: one payload bit per request.
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_bit_value,
   input  logic                           req_first_bit,
   input  logic                           req_last_bit,
   // Result channel: one decoded sample or status per result.
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output fprd_pkg::sample_type           rsp_sample,
   output fprd_pkg::status_type           rsp_status,
   output logic                           rsp_last,
   // Configuration port.
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [fprd_pkg::PADDR_W-1:0]   paddr,
   input  logic [fprd_pkg::DATA_W-1:0]    pwdata,
   output logic [fprd_pkg::DATA_W-1:0]    prdata,
   output logic                           pready
);

   // Request register. It holds one accepted bit until the frame logic
   // consumes it; the frame logic consumes it whenever the result register
   // is free or is being emptied in the same cycle.
   logic in_valid_ff, in_valid_in;
   logic in_bit_ff, in_first_ff, in_last_ff;

   // Result register. While rsp_ready stays high it is emptied every cycle,
   // so bits keep flowing; a result left waiting holds the frame logic.
   logic                 out_valid_ff, out_valid_in;
   fprd_pkg::sample_type out_sample_ff;
   fprd_pkg::status_type out_status_ff;
   logic                 out_last_ff;

   logic                       fire;
   logic                       accept;
   logic [fprd_pkg::CFG_W-1:0] expected_samples;
   fprd_pkg::result_type       step_result;

   fprd_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .expected_samples (expected_samples)
   );

   // The frame logic advances only on a cycle where its bit is consumed,
   // so its state and the result register always move together.
   assign fire      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign accept    = req_valid && req_ready;

   fprd_frame u_frame (
      .clock            (clock),
      .reset            (reset),
      .fire             (fire),
      .bit_value        (in_bit_ff),
      .first_bit        (in_first_ff),
      .last_bit         (in_last_ff),
      .expected_samples (expected_samples),
      .result           (step_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff && !rsp_ready;
      if (fire) begin
         out_valid_in = step_result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers load without reset; their valid flags guard them.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_bit_ff   <= req_bit_value;
         in_first_ff <= req_first_bit;
         in_last_ff  <= req_last_bit;
      end
      if (fire && step_result.valid) begin
         out_sample_ff <= step_result.sample;
         out_status_ff <= step_result.status;
         out_last_ff   <= step_result.last;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_sample = out_sample_ff;
   assign rsp_status = out_status_ff;
   assign rsp_last   = out_last_ff;

endmodule

[rtl/fprd_checker.sv]
// Port-level assertions for the Rice decoder, bound to the top level.
// Depends on fprd_pkg and on the top level's port names.
module fprd_props (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input fprd_pkg::sample_type           rsp_sample,
   input fprd_pkg::status_type           rsp_status,
   input logic                           rsp_last
);

   // A stalled result keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample) &&
                                  $stable(rsp_status) && $stable(rsp_last))
      else $error("result changed while stalled");

   // Every error result ends the frame.
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != fprd_pkg::ST_OK |-> rsp_last)
      else $error("error result without last");

   // Error results carry a zero sample.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != fprd_pkg::ST_OK |-> rsp_sample == '0)
      else $error("error result with nonzero sample");

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind fixed_predictor_rice_decoder fprd_props u_fprd_props (.*);

[test/fprd_checker.sv]
// Checker for the fixed-predictor Rice decoder: watches the request, result and
// configuration ports, decodes every accepted bit itself and compares results.
// Depends on fprd_pkg for the sample and status types and the status codes.
module fprd_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic                           req_bit_value,
   input  logic                           req_first_bit,
   input  logic                           req_last_bit,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  fprd_pkg::sample_type           rsp_sample,
   input  fprd_pkg::status_type           rsp_status,
   input  logic                           rsp_last,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic                           pready,
   input  logic [fprd_pkg::PADDR_W-1:0]   paddr,
   input  logic [fprd_pkg::DATA_W-1:0]    pwdata,
   output int                             fail_count,
   output int                             pending_count
);

   typedef enum logic [2:0] {
      PH_IDLE, PH_HEADER, PH_SEED, PH_QUOT, PH_REM, PH_DONE
   } frame_phase_type;

   typedef struct {
      fprd_pkg::sample_type sample;
      fprd_pkg::status_type status;
      logic                 last;
   } sample_result_type;

   logic [fprd_pkg::CFG_W-1:0] cfg_expected;
   frame_phase_type            phase;
   logic [15:0]                field_word;
   int unsigned                bit_pos;
   int unsigned                version;
   int unsigned                order;
   int unsigned                rice_k;
   int unsigned                quotient;
   int unsigned                remainder;
   int                         hist[4];
   int unsigned                hist_fill;
   logic [15:0]                decoded_count;
   sample_result_type          pending_samples[$];
   int                         mismatches;

   function automatic void clear_frame();
      phase = PH_IDLE;
      field_word = '0;
      bit_pos = 0;
      version = 0;
      order = 0;
      rice_k = 0;
      quotient = 0;
      remainder = 0;
      hist = '{0, 0, 0, 0};
      hist_fill = 0;
      decoded_count = '0;
   endfunction

   function automatic int unsigned seed_total();
      return (version == 3) ? order : 2;
   endfunction

   function automatic fprd_pkg::status_type check_header();
      int unsigned ver;
      int unsigned ctrl;
      int unsigned ord;
      int unsigned k;
      ver = {24'd0, field_word[7:0]};
      ctrl = {24'd0, field_word[15:8]};
      if (ver == 1) begin
         ord = 2;
         k = ctrl;
      end else if (ver == 2 || ver == 3) begin
         ord = ctrl >> 4;
         k = ctrl & 15;
      end else begin
         return fprd_pkg::ST_VERSION;
      end
      if (ord < 1 || ord > 4 || (ver != 3 && ord > 2))
         return fprd_pkg::ST_PREDICTOR;
      if (k > 15)
         return fprd_pkg::ST_PARAM;
      version = ver;
      order = ord;
      rice_k = k;
      if (cfg_expected < seed_total())
         return fprd_pkg::ST_TRUNC;
      return fprd_pkg::ST_OK;
   endfunction

   // Returns 1 when this sample completes the frame.
   function automatic bit push_sample(int s);
      hist[3] = hist[2];
      hist[2] = hist[1];
      hist[1] = hist[0];
      hist[0] = s;
      if (hist_fill < 4)
         hist_fill++;
      decoded_count = decoded_count + 16'd1;
      return decoded_count >= cfg_expected;
   endfunction

   function automatic int predict();
      case (order)
         1: return hist[0];
         2: return 2 * hist[0] - hist[1];
         3: return 3 * hist[0] - 3 * hist[1] + hist[2];
         default: return 4 * hist[0] - 6 * hist[1] + 4 * hist[2] - hist[3];
      endcase
   endfunction

   // Advances the frame by one payload bit; sets produced when a result is due.
   function automatic void decode_bit(input bit b, input bit first, input bit last,
                                      output bit produced, output sample_result_type res);
      fprd_pkg::status_type err;
      bit                   have;
      bit                   fin;
      bit                   code_done;
      int                   val;
      int unsigned          zig;
      int                   half;
      int                   s;
      produced = 1'b0;
      res.sample = '0;
      res.status = fprd_pkg::ST_OK;
      res.last = 1'b0;
      err = fprd_pkg::ST_OK;
      have = 1'b0;
      fin = 1'b0;
      code_done = 1'b0;
      val = 0;
      if (first) begin
         clear_frame();
         if (cfg_expected < fprd_pkg::MIN_EXPECTED) begin
            phase = PH_DONE;
            res.status = fprd_pkg::ST_BAD_ARG;
            res.last = 1'b1;
            produced = 1'b1;
            return;
         end
         phase = PH_HEADER;
      end
      if (phase == PH_IDLE || phase == PH_DONE)
         return;

      case (phase)
         PH_HEADER, PH_SEED: begin
            field_word[bit_pos] = b;
            if (bit_pos < 15) begin
               bit_pos++;
            end else begin
               bit_pos = 0;
               if (phase == PH_HEADER) begin
                  err = check_header();
                  phase = PH_SEED;
               end else begin
                  val = int'($signed(field_word));
                  have = 1'b1;
                  fin = push_sample(val);
                  if (!fin && hist_fill >= seed_total())
                     phase = PH_QUOT;
               end
               field_word = '0;
            end
         end
         PH_QUOT: begin
            if (b) begin
               remainder = 0;
               bit_pos = 0;
               if (rice_k == 0)
                  code_done = 1'b1;
               else
                  phase = PH_REM;
            end else begin
               quotient++;
               if (quotient > (fprd_pkg::MAX_ZIGZAG >> rice_k))
                  err = fprd_pkg::ST_RESIDUAL;
            end
         end
         default: begin
            remainder = remainder | (int'(b) << bit_pos);
            bit_pos++;
            if (bit_pos >= rice_k)
               code_done = 1'b1;
         end
      endcase

      if (code_done) begin
         zig = (quotient << rice_k) | remainder;
         if (zig > fprd_pkg::MAX_ZIGZAG) begin
            err = fprd_pkg::ST_RESIDUAL;
         end else begin
            half = int'(zig >> 1);
            s = predict() + (zig[0] ? -half - 1 : half);
            if (s < -32768 || s > 32767) begin
               err = fprd_pkg::ST_SAMPLE;
            end else begin
               val = s;
               have = 1'b1;
               fin = push_sample(s);
               phase = PH_QUOT;
               quotient = 0;
               remainder = 0;
               bit_pos = 0;
            end
         end
      end

      if (err != fprd_pkg::ST_OK) begin
         phase = PH_DONE;
         res.status = err;
         res.last = 1'b1;
         produced = 1'b1;
      end else if (have && fin) begin
         phase = PH_DONE;
         res.sample = val[15:0];
         res.last = 1'b1;
         produced = 1'b1;
      end else if (last) begin
         phase = PH_DONE;
         res.status = fprd_pkg::ST_TRUNC;
         res.last = 1'b1;
         produced = 1'b1;
      end else if (have) begin
         res.sample = val[15:0];
         produced = 1'b1;
      end
   endfunction

   always @(posedge clock) begin
      sample_result_type want;
      bit                produced;
      if (reset) begin
         cfg_expected = fprd_pkg::EXPECTED_RESET;
         clear_frame();
         pending_samples.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_samples.size() == 0) begin
               $display("%0t: unexpected result sample %0d status %0d last %0b",
                        $time, rsp_sample, rsp_status, rsp_last);
               mismatches++;
            end else begin
               want = pending_samples.pop_front();
               if (rsp_sample !== want.sample) begin
                  $display("%0t: sample mismatch, expected %0d, got %0d",
                           $time, want.sample, rsp_sample);
                  mismatches++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d, got %0d",
                           $time, want.status, rsp_status);
                  mismatches++;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t: last mismatch, expected %0b, got %0b",
                           $time, want.last, rsp_last);
                  mismatches++;
               end
            end
         end
         if (psel && penable && pwrite && pready &&
             paddr[fprd_pkg::PADDR_W-1:2] == fprd_pkg::REG_EXPECTED)
            cfg_expected = pwdata[fprd_pkg::CFG_W-1:0];
         if (req_valid && req_ready) begin
            decode_bit(req_bit_value, req_first_bit, req_last_bit, produced, want);
            if (produced)
               pending_samples.push_back(want);
         end
      end
      fail_count <= mismatches;
      pending_count <= pending_samples.size();
   end

endmodule

[test/tb_top.sv]
// Top of the Rice decoder testbench: clock, reset, request and result drivers
// and the configuration writes; prediction and comparison live in fprd_checker.
// Depends on fprd_pkg, fprd_checker and fixed_predictor_rice_decoder.
module tb_top;

   // Random part stops after this many request bits; the directed part
   // before it sends roughly as many again.
   localparam int RANDOM_BITS = 950;
   // Generous ceiling on the whole run, well above the slowest legal run.
   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_GAP = 17;
   // Format version codes carried in the first payload byte.
   localparam int FMT_V1 = 1;
   localparam int FMT_V2 = 2;
   localparam int FMT_V3 = 3;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic                         req_bit_value;
   logic                         req_first_bit;
   logic                         req_last_bit;
   logic                         rsp_valid;
   logic                         rsp_ready;
   fprd_pkg::sample_type         rsp_sample;
   fprd_pkg::status_type         rsp_status;
   logic                         rsp_last;
   logic                         psel;
   logic                         penable;
   logic                         pwrite;
   logic [fprd_pkg::PADDR_W-1:0] paddr;
   logic [fprd_pkg::DATA_W-1:0]  pwdata;
   logic [fprd_pkg::DATA_W-1:0]  prdata;
   logic                         pready;

   int fail_count;
   int pending_count;
   int cycle_count;
   int bits_sent;

   // Handshake flags, registered at the rising edge and read at the falling one,
   // so the drivers never race the block's own updates.
   logic req_took;
   logic rsp_took;

   // Stimulus-side knobs: random idling on each side, and the programmed length.
   bit          idle_gaps;
   bit          rsp_stalls;
   logic [15:0] cur_expected;

   // Bits of the frame that is about to be sent, and seeds to force into it.
   bit frame_q[$];
   int forced_seeds[$];

   fixed_predictor_rice_decoder uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_bit_value (req_bit_value),
      .req_first_bit (req_first_bit),
      .req_last_bit  (req_last_bit),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_sample    (rsp_sample),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   fprd_checker sample_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_bit_value (req_bit_value),
      .req_first_bit (req_first_bit),
      .req_last_bit  (req_last_bit),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_sample    (rsp_sample),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .pready        (pready),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      req_took <= req_valid && req_ready;
      rsp_took <= rsp_valid && rsp_ready;
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Result side: after every accepted result, optionally hold ready low for a
   // random number of cycles, then keep it high until the next result goes.
   initial begin
      int gap;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = rsp_stalls ? $urandom_range(0, MAX_GAP) : 0;
         if (gap > 0) begin
            rsp_ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(negedge clock); while (!rsp_took);
      end
   end

   function automatic int clamp_sample(int s);
      if (s > 32767)
         return 32767;
      if (s < -32768)
         return -32768;
      return s;
   endfunction

   // Appends the n low bits of v, least significant first.
   function automatic void push_bits(int v, int n);
      for (int i = 0; i < n; i++)
         frame_q.push_back(v[i]);
   endfunction

   // Rice code: unary quotient in zeros, a closing one, then k remainder bits.
   function automatic void push_code(int zig, int k);
      repeat (zig >> k) frame_q.push_back(1'b0);
      frame_q.push_back(1'b1);
      push_bits(zig, k);
   endfunction

   // Builds a frame of nsamp samples. Seeds follow a random walk (or come from
   // forced_seeds); later samples are drawn near the prediction so the codes
   // stay short. A code that would be very long ends the frame early, and a
   // sample pushed out of range is kept now and then to provoke an overflow.
   function automatic void build_frame(int ver, int ord, int k, int nsamp);
      int hist_w[4];
      int nseeds;
      int pred;
      int r;
      int s;
      int span;
      int zig;
      bit overflow;
      frame_q.delete();
      if (ver == FMT_V1)
         ord = 2;
      push_bits(ver, 8);
      push_bits((ver == FMT_V1) ? k : ((ord << 4) | (k & 15)), 8);
      nseeds = (ver == FMT_V3) ? ord : 2;
      hist_w = '{0, 0, 0, 0};
      span = 1 << (k & 15);
      for (int i = 0; i < nsamp; i++) begin
         overflow = 1'b0;
         if (i < nseeds) begin
            if (forced_seeds.size() > 0)
               s = forced_seeds.pop_front();
            else if (i == 0 || $urandom_range(0, 7) == 0)
               s = int'($urandom_range(0, 65535)) - 32768;
            else
               s = clamp_sample(hist_w[0] + int'($urandom_range(0, 400)) - 200);
            push_bits(s, 16);
         end else begin
            case (ord)
               1: pred = hist_w[0];
               2: pred = 2 * hist_w[0] - hist_w[1];
               3: pred = 3 * hist_w[0] - 3 * hist_w[1] + hist_w[2];
               default: pred = 4 * hist_w[0] - 6 * hist_w[1] + 4 * hist_w[2] - hist_w[3];
            endcase
            s = pred + int'($urandom_range(0, 2 * span)) - span;
            if (s != clamp_sample(s) && $urandom_range(0, 3) != 0)
               s = clamp_sample(s);
            overflow = (s != clamp_sample(s));
            r = s - pred;
            zig = (r < 0) ? -2 * r - 1 : 2 * r;
            if ((zig >> (k & 15)) > 48)
               break;
            push_code(zig, k & 15);
            if (overflow)
               break;
         end
         hist_w[3] = hist_w[2];
         hist_w[2] = hist_w[1];
         hist_w[1] = hist_w[0];
         hist_w[0] = s;
      end
   endfunction

   // One request: an optional random gap with valid low, then valid high with
   // the payload until the block takes it. Valid stays high when no gap follows.
   task automatic send_bit(input bit b, input bit first, input bit last);
      int gap;
      gap = idle_gaps ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_bit_value = b;
      req_first_bit = first;
      req_last_bit = last;
      do @(negedge clock); while (!req_took);
      bits_sent++;
   endtask

   task automatic send_frame(input int restart_at, input bit mark_last);
      for (int i = 0; i < frame_q.size(); i++)
         send_bit(frame_q[i], i == 0 || i == restart_at,
                  mark_last && i == frame_q.size() - 1);
   endtask

   // A bare header ended with last set: exercises the header checks.
   task automatic header_only(input int ver, input int ctrl);
      frame_q.delete();
      push_bits(ver, 8);
      push_bits(ctrl, 8);
      send_frame(-1, 1'b1);
   endtask

   // The sender holds off until every predicted result has arrived, then idles on
   // until a bit still in the two-stage pipeline that gives no result is through.
   task automatic wait_drained();
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Register writes go in only while the block is drained.
   task automatic write_expected(input logic [15:0] value);
      wait_drained();
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = '0;
      paddr[fprd_pkg::PADDR_W-1:2] = fprd_pkg::REG_EXPECTED;
      pwdata = fprd_pkg::DATA_W'(value);
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      cur_expected = value;
   endtask

   initial begin
      bit head[$];
      int random_start;
      int frames_left;
      int kind;
      int ver;
      int ord;
      int k;
      int len;
      int pick;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_bit_value = 1'b0;
      req_first_bit = 1'b0;
      req_last_bit = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      cycle_count = 0;
      bits_sent = 0;
      idle_gaps = 1'b1;
      rsp_stalls = 1'b1;
      cur_expected = fprd_pkg::EXPECTED_RESET;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // Directed part. Bits before any frame start are ignored.
      send_bit(1'b1, 1'b0, 1'b0);
      send_bit(1'b0, 1'b0, 1'b1);

      // Two extreme seeds at the reset length; the trailing bits are ignored.
      forced_seeds = '{32767, -32768};
      build_frame(FMT_V1, 2, 3, 2);
      send_frame(-1, 1'b1);
      repeat (3) send_bit(1'b1, 1'b0, 1'b1);

      // A length below two is rejected on the first bit of the frame.
      write_expected(16'd1);
      send_bit(1'b1, 1'b1, 1'b0);
      send_bit(1'b0, 1'b0, 1'b1);
      write_expected(16'd0);
      send_bit(1'b0, 1'b1, 1'b1);

      // Header checks: unknown versions, bad orders, a k that does not fit in
      // a nibble, and a good header cut off before its seeds.
      write_expected(16'd6);
      header_only(0, 8'h12);
      header_only(8'hFF, 8'h00);
      header_only(FMT_V2, 8'h30);
      header_only(FMT_V3, 8'h02);
      header_only(FMT_V3, 8'h53);
      header_only(FMT_V1, 8'h10);
      header_only(FMT_V2, 8'h1F);

      // Fewer samples requested than an order-four header carries seeds.
      write_expected(16'd3);
      build_frame(FMT_V3, 4, 2, 3);
      send_frame(-1, 1'b1);

      // Sums that leave the 16-bit range on both sides.
      write_expected(16'd6);
      forced_seeds = '{32767, 32767};
      build_frame(FMT_V2, 1, 0, 2);
      push_code(2, 0);
      send_frame(-1, 1'b1);
      forced_seeds = '{-32768, -32768};
      build_frame(FMT_V2, 1, 0, 2);
      push_code(1, 0);
      send_frame(-1, 1'b1);

      // A quotient run too long for k = 15; the error lands on the last bit,
      // so the residual error must win over truncation.
      forced_seeds = '{0, 0};
      build_frame(FMT_V2, 1, 15, 2);
      repeat (32) frame_q.push_back(1'b0);
      send_frame(-1, 1'b1);

      // Last set on a bit that completes a sample short of the frame length.
      build_frame(FMT_V3, 1, 1, 4);
      send_frame(-1, 1'b1);

      // Complete frames for the higher orders and the largest k.
      build_frame(FMT_V3, 3, 4, 6);
      send_frame(-1, 1'b1);
      build_frame(FMT_V3, 4, 0, 6);
      send_frame(-1, 1'b1);
      build_frame(FMT_V2, 2, 15, 6);
      send_frame(-1, 1'b1);

      // A new first bit in the middle of a frame restarts decoding.
      build_frame(FMT_V3, 3, 2, 6);
      head = frame_q[0:29];
      build_frame(FMT_V2, 2, 1, 6);
      frame_q = {head, frame_q};
      send_frame(30, 1'b1);

      // The largest length can only end in truncation here.
      write_expected(16'hFFFF);
      build_frame(FMT_V2, 2, 2, 5);
      send_frame(-1, 1'b1);

      // Random part: phases of a few frames, each with its own length and
      // idling pattern. Most frames are well formed with random content.
      random_start = bits_sent;
      frames_left = 0;
      while (bits_sent - random_start < RANDOM_BITS) begin
         if (frames_left == 0) begin
            pick = $urandom_range(0, 19);
            case (pick)
               0: write_expected(16'd0);
               1: write_expected(16'd1);
               2: write_expected(16'hFFFF);
               3: write_expected(16'd2);
               default: write_expected(16'($urandom_range(2, 10)));
            endcase
            idle_gaps = ($urandom_range(0, 3) != 0);
            rsp_stalls = ($urandom_range(0, 3) != 0);
            frames_left = $urandom_range(3, 6);
         end
         frames_left--;

         ver = $urandom_range(FMT_V1, FMT_V3);
         ord = (ver == FMT_V3) ? $urandom_range(1, 4) : $urandom_range(1, 2);
         k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 5);
         len = (cur_expected > 12) ? 12 : cur_expected;
         build_frame(ver, ord, k, len);
         kind = (cur_expected < fprd_pkg::MIN_EXPECTED) ? 9 : $urandom_range(0, 9);

         if (kind <= 5) begin
            // Well formed, now and then preceded by stray bits or followed
            // by bits that arrive after the frame has ended.
            if ($urandom_range(0, 7) == 0)
               send_bit(1'($urandom_range(0, 1)), 1'b0, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) == 0) begin
               repeat ($urandom_range(1, 6)) frame_q.push_back(1'($urandom_range(0, 1)));
            end
            send_frame(-1, 1'b1);
         end else if (kind == 6 || kind == 7) begin
            // Corrupted: flip one or two bits, all within the first 48 bits of the frame.
            repeat ($urandom_range(1, 2)) begin
               pick = (frame_q.size() > 48) ? $urandom_range(0, 47)
                                            : $urandom_range(0, frame_q.size() - 1);
               frame_q[pick] = !frame_q[pick];
            end
            send_frame(-1, 1'b1);
         end else if (kind == 8) begin
            // Cut short, mostly with last on the final bit; without it the
            // next frame's first bit abandons this one.
            len = $urandom_range(1, frame_q.size());
            frame_q = frame_q[0:len-1];
            send_frame(-1, $urandom_range(0, 3) != 0);
         end else begin
            // Noise, with an occasional restart inside it.
            frame_q.delete();
            len = (cur_expected < fprd_pkg::MIN_EXPECTED) ? $urandom_range(1, 6)
                                                            : $urandom_range(1, 60);
            repeat (len) frame_q.push_back(1'($urandom_range(0, 1)));
            send_frame(($urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1) : -1,
                       $urandom_range(0, 1) != 0);
         end
      end

      wait_drained();
      repeat (8) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
